FILE: rtl/chat_datagram_validator_assert.svh
// ----------------------------------------------------------------------------
// Chat datagram validator assertion macros
// Shared macros for the concurrent checks of the validator. They sample on
// the rising edge of clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CHAT_DATAGRAM_VALIDATOR_ASSERT_SVH
`define CHAT_DATAGRAM_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chat datagram validator check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chat datagram validator check failed");

`endif

FILE: rtl/cdv_pkg.sv
// ----------------------------------------------------------------------------
// Chat datagram validator package
// Payload types, message classes, register indexes and position constants
// shared by the validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdv_pkg;

  // One received byte and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } byte_t;

  // One verdict for a complete datagram.
  typedef struct packed {
    logic       malformed;
    logic [7:0] message_type;
  } result_t;

  // Type codes of all message kinds, as held in the configuration registers.
  typedef struct packed {
    logic [7:0] confirm;
    logic [7:0] reply;
    logic [7:0] auth;
    logic [7:0] join_msg;
    logic [7:0] chat;
    logic [7:0] ping;
    logic [7:0] error;
    logic [7:0] bye;
  } codes_t;

  // Message class that decides which rules apply.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SHORT,
    KIND_REPLY,
    KIND_TAIL
  } kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTH    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_JOIN    = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAT    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PING    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_BYE     = 4'd7;

  // Reset values of the type codes.
  localparam codes_t CODES_RESET = '{
    confirm: 8'd0,   reply: 8'd1,   auth: 8'd2,   join_msg: 8'd3,
    chat:    8'd4,   ping:  8'd253, error: 8'd254, bye: 8'd255
  };

  // Byte positions (position saturates at its maximum).
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_MAX          = 3'd7;
  localparam logic [POS_W-1:0] TAIL_START       = 3'd3;
  localparam logic [POS_W-1:0] REPLY_TAIL_START = 3'd6;
  localparam logic [POS_W-1:0] REPLY_RESULT_POS = 3'd3;
  // Lowest allowed position of the final byte; lower ones are too short.
  localparam logic [POS_W-1:0] MIN_LAST_POS       = 3'd2;
  localparam logic [POS_W-1:0] REPLY_MIN_LAST_POS = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/chat_datagram_validator.sv
// ----------------------------------------------------------------------------
// Chat datagram validator
// Checks a datagram that arrives one byte per request and returns one
// verdict request (malformed flag and type byte) on the final byte.
//
//   channel   | direction | handshake            | payload
//   byte      | in        | byte_valid/stall     | cdv_pkg::byte_t
//   result    | out       | result_valid/stall   | cdv_pkg::result_t
//   cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle is sustained unless a final byte stalls. A final
// byte's verdict is registered in the result register as it leaves.
// Reset (rst, synchronous) restores the default type codes and clears the
// per-datagram state. A final byte waits in the input register only while
// the result register holds a verdict that is stalled; other bytes move on.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chat_datagram_validator_assert.svh"

module chat_datagram_validator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  cdv_pkg::byte_t                       byte_data,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output cdv_pkg::result_t                     result_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cdv_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [7:0]                           cfg_data
);
  import cdv_pkg::*;

  // Input register.
  logic  s1_valid;
  byte_t s1_data;

  // Per-datagram state and configuration.
  logic [POS_W-1:0] byte_position;
  logic [7:0]       type_held;
  logic             rule_broken;
  logic             previous_was_data;
  logic [POS_W-1:0] terminator_count;
  codes_t           codes;

  // Next values and decode.
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       type_cur;
  logic             rule_broken_next;
  logic             previous_was_data_next;
  logic [POS_W-1:0] terminator_count_next;
  logic             in_tail;
  logic             bad;
  logic             advance;
  logic             final_move;
  logic             accept;
  kind_t            kind;
  logic [1:0]       fields;

  // A non-final byte always moves on; a final one needs room for its verdict.
  assign advance    = s1_valid &&
                      (!s1_data.end_of_datagram || !result_valid || !result_stall);
  assign final_move = advance && s1_data.end_of_datagram;
  assign byte_stall = s1_valid && !advance;
  assign accept     = byte_valid && !byte_stall;
  assign cfg_ready  = 1'b1;

  // Type byte of the datagram in flight.
  assign type_cur = (byte_position == '0) ? s1_data.data_byte : type_held;

  cdv_classify u_classify (
    .codes     (codes),
    .type_code (type_cur),
    .kind      (kind),
    .fields    (fields)
  );

  // Rule checks for the byte in the input register.
  always_comb begin
    rule_broken_next       = rule_broken;
    previous_was_data_next = previous_was_data;
    terminator_count_next  = terminator_count;
    in_tail = (kind == KIND_REPLY) ? (byte_position >= REPLY_TAIL_START)
                                   : (byte_position >= TAIL_START);
    unique case (kind)
      KIND_NONE: begin
        rule_broken_next = 1'b1;
      end
      KIND_SHORT: begin
        if (byte_position >= TAIL_START) begin
          rule_broken_next = 1'b1;
        end
      end
      default: begin
        if (kind == KIND_REPLY && byte_position == REPLY_RESULT_POS &&
            s1_data.data_byte > 8'd1) begin
          rule_broken_next = 1'b1;
        end
        if (in_tail) begin
          if (s1_data.data_byte == 8'd0) begin
            if (!previous_was_data) begin
              rule_broken_next = 1'b1;
            end
            if (terminator_count != POS_MAX) begin
              terminator_count_next = terminator_count + 1'b1;
            end
            previous_was_data_next = 1'b0;
          end else begin
            previous_was_data_next = 1'b1;
          end
        end
      end
    endcase

    // Verdict, meaningful on the final byte only.
    bad = rule_broken_next || (byte_position < MIN_LAST_POS) ||
          (kind == KIND_REPLY && byte_position < REPLY_MIN_LAST_POS);
    if ((kind == KIND_REPLY || kind == KIND_TAIL) && in_tail) begin
      if (s1_data.data_byte != 8'd0 ||
          terminator_count_next != {1'b0, fields}) begin
        bad = 1'b1;
      end
    end

    byte_position_next = (byte_position == POS_MAX) ? POS_MAX
                                                    : byte_position + 1'b1;
    // The final byte returns the datagram state to its start.
    if (s1_data.end_of_datagram) begin
      byte_position_next     = '0;
      rule_broken_next       = 1'b0;
      previous_was_data_next = 1'b0;
      terminator_count_next  = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_data <= byte_data;
    end
  end

  // Datagram state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      type_held         <= 8'd0;
      rule_broken       <= 1'b0;
      previous_was_data <= 1'b0;
      terminator_count  <= '0;
    end else if (advance) begin
      byte_position     <= byte_position_next;
      type_held         <= type_cur;
      rule_broken       <= rule_broken_next;
      previous_was_data <= previous_was_data_next;
      terminator_count  <= terminator_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (final_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (final_move) begin
      result_data.malformed    <= bad;
      result_data.message_type <= type_cur;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      codes <= CODES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CONFIRM: codes.confirm  <= cfg_data;
        REG_REPLY:   codes.reply    <= cfg_data;
        REG_AUTH:    codes.auth     <= cfg_data;
        REG_JOIN:    codes.join_msg <= cfg_data;
        REG_CHAT:    codes.chat     <= cfg_data;
        REG_PING:    codes.ping     <= cfg_data;
        REG_ERROR:   codes.error    <= cfg_data;
        REG_BYE:     codes.bye      <= cfg_data;
        default: ;
      endcase
    end
  end

  // A final byte always produces a verdict and restarts the datagram.
  `CDV_ASSERT_NEXT(a_final_gives_result, final_move, result_valid)
  `CDV_ASSERT_NEXT(a_final_restarts, final_move, byte_position == '0 && terminator_count == '0)
  // Terminators are counted only on positions that were passed.
  `CDV_ASSERT_SAME(a_term_le_pos, 1'b1, terminator_count <= byte_position)
  // Stall is raised only for a final byte blocked by a stalled verdict.
  `CDV_ASSERT_SAME(a_stall_cause, byte_stall, s1_data.end_of_datagram && result_valid && result_stall)

endmodule

`default_nettype wire

FILE: rtl/cdv_classify.sv
// ----------------------------------------------------------------------------
// Chat datagram type classifier
// Maps a type byte onto a message class and the expected number of text
// fields, using the configured codes in a fixed priority order.
// ----------------------------------------------------------------------------
`default_nettype none

module cdv_classify (
  input  cdv_pkg::codes_t codes,
  input  logic [7:0]      type_code,
  output cdv_pkg::kind_t  kind,
  output logic [1:0]      fields
);
  import cdv_pkg::*;

  // Priority chain: confirm, ping, reply, auth, join, chat, error, bye.
  always_comb begin
    kind   = KIND_NONE;
    fields = 2'd0;
    if (type_code == codes.confirm || type_code == codes.ping) begin
      kind = KIND_SHORT;
    end else if (type_code == codes.reply) begin
      kind   = KIND_REPLY;
      fields = 2'd1;
    end else if (type_code == codes.auth) begin
      kind   = KIND_TAIL;
      fields = 2'd3;
    end else if (type_code == codes.join_msg || type_code == codes.chat ||
                 type_code == codes.error) begin
      kind   = KIND_TAIL;
      fields = 2'd2;
    end else if (type_code == codes.bye) begin
      kind   = KIND_TAIL;
      fields = 2'd1;
    end
  end

endmodule

`default_nettype wire
